// ----- sv/mono_bitmap_color_expand_assert.svh -----
// Assertion macros for the colour expansion blitter
`ifndef MONO_BITMAP_COLOR_EXPAND_ASSERT_SVH
`define MONO_BITMAP_COLOR_EXPAND_ASSERT_SVH

`ifndef SYNTHESIS
`define MBCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbce: implication check failed");
`define MBCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbce: next-cycle check failed");
`else
`define MBCE_ASSERT_IMP(lbl, ante, cons)
`define MBCE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/mbce_pkg.sv -----
package mbce_pkg;

    localparam int COORD_BITS  = 12;
    localparam int OFFSET_BITS = 28;
    localparam int PITCH_BITS  = 16;
    localparam int BPP_BITS    = 3;
    localparam int CHAN_BITS   = 8;
    localparam int COLOR_BITS  = 3 * CHAN_BITS;
    localparam int PIX_PER_BYTE = 8;
    localparam int PIX_SHIFT   = 3;
    localparam int COUNT_BITS  = 4;
    localparam int COL_BITS    = COORD_BITS - PIX_SHIFT;
    localparam int ROWB_BITS   = COL_BITS + 1;
    localparam int YTERM_BITS  = COORD_BITS + PITCH_BITS;
    localparam int XTERM_BITS  = COORD_BITS + BPP_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COLOR_BITS;

    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + CHAN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((OFFSET_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_SCREEN_HEIGHT   = 3'd1,
        REG_LINE_PITCH      = 3'd2,
        REG_BYTES_PER_PIXEL = 3'd3,
        REG_FORE_COLOR      = 3'd4,
        REG_BACK_COLOR      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] screen_width;
        logic [COORD_BITS-1:0] screen_height;
        logic [PITCH_BITS-1:0] line_pitch;
        logic [BPP_BITS-1:0]   bytes_per_pixel;
        logic [COLOR_BITS-1:0] fore_color;
        logic [COLOR_BITS-1:0] back_color;
    } cfg_t;

    // one bitmap byte that has visible pixels, ready for expansion
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [COUNT_BITS-1:0]  count;
        logic [CHAN_BITS-1:0]   data;
        logic                   last_bitmap;
    } cmd_t;

endpackage

// ----- sv/mbce_front.sv -----
module mbce_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbce_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_mode,
    input  logic [mbce_pkg::COORD_BITS-1:0] in_x,
    input  logic [mbce_pkg::COORD_BITS-1:0] in_y,
    input  logic [mbce_pkg::COORD_BITS-1:0] in_w,
    input  logic [mbce_pkg::COORD_BITS-1:0] in_h,
    input  logic [mbce_pkg::CHAN_BITS-1:0]  in_byte,
    input  logic                           q_full,
    output logic                           q_push,
    output mbce_pkg::cmd_t                 q_cmd
);
    import mbce_pkg::*;

    logic                   active_reg, active_next;
    logic [COORD_BITS-1:0]  bm_width_reg, bm_width_next;
    logic [COORD_BITS-1:0]  bm_height_reg, bm_height_next;
    logic [COORD_BITS-1:0]  vis_w_reg, vis_w_next;
    logic [COORD_BITS-1:0]  vis_h_reg, vis_h_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [COORD_BITS-1:0]  row_reg, row_next;
    logic [OFFSET_BITS-1:0] row_base_reg, row_base_next;

    logic                   accept;
    logic                   off_screen;
    logic [COORD_BITS:0]    x_end, y_end;
    logic [COORD_BITS-1:0]  start_vw, start_vh;
    logic [YTERM_BITS-1:0]  y_term;
    logic [XTERM_BITS-1:0]  x_term, col_term;
    logic [COORD_BITS:0]    w_round;
    logic [ROWB_BITS-1:0]   row_bytes;
    logic [ROWB_BITS-1:0]   col_inc;
    logic [COORD_BITS-1:0]  first_x;
    logic [COORD_BITS-1:0]  remain;
    logic [COORD_BITS:0]    row_inc;
    logic                   has_pix;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // start request: clip against the screen
    assign off_screen = (in_x >= cfg.screen_width) || (in_y >= cfg.screen_height);
    assign x_end = {1'b0, in_x} + {1'b0, in_w};
    assign y_end = {1'b0, in_y} + {1'b0, in_h};
    assign start_vw = off_screen ? '0 :
                      (x_end > {1'b0, cfg.screen_width}) ? cfg.screen_width - in_x : in_w;
    assign start_vh = off_screen ? '0 :
                      (y_end > {1'b0, cfg.screen_height}) ? cfg.screen_height - in_y : in_h;
    assign y_term = YTERM_BITS'(in_y) * YTERM_BITS'(cfg.line_pitch);
    assign x_term = XTERM_BITS'(in_x) * XTERM_BITS'(cfg.bytes_per_pixel);

    // byte request: visible span of this byte
    assign w_round   = {1'b0, bm_width_reg} + (COORD_BITS+1)'(PIX_PER_BYTE - 1);
    assign row_bytes = w_round[COORD_BITS:PIX_SHIFT];
    assign col_inc   = {1'b0, col_reg} + ROWB_BITS'(1);
    assign first_x   = {col_reg, {PIX_SHIFT{1'b0}}};
    assign remain    = vis_w_reg - first_x;
    assign row_inc   = {1'b0, row_reg} + (COORD_BITS+1)'(1);
    assign has_pix   = (row_reg < vis_h_reg) && (first_x < vis_w_reg);
    assign col_term  = XTERM_BITS'(first_x) * XTERM_BITS'(cfg.bytes_per_pixel);

    assign q_push = accept && (in_mode == MODE_BYTE) && active_reg && has_pix;

    always_comb
    begin
        q_cmd.offset = row_base_reg + OFFSET_BITS'(col_term);
        q_cmd.count  = (remain >= COORD_BITS'(PIX_PER_BYTE)) ? COUNT_BITS'(PIX_PER_BYTE)
                                                            : remain[COUNT_BITS-1:0];
        q_cmd.data   = in_byte;
        q_cmd.last_bitmap = (row_inc == {1'b0, vis_h_reg})
                            && (remain <= COORD_BITS'(PIX_PER_BYTE));
    end

    always_comb
    begin
        active_next    = active_reg;
        bm_width_next  = bm_width_reg;
        bm_height_next = bm_height_reg;
        vis_w_next     = vis_w_reg;
        vis_h_next     = vis_h_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        row_base_next  = row_base_reg;
        if (accept)
        begin
            if (in_mode == MODE_START)
            begin
                bm_width_next  = in_w;
                bm_height_next = in_h;
                vis_w_next     = start_vw;
                vis_h_next     = start_vh;
                col_next       = '0;
                row_next       = '0;
                row_base_next  = OFFSET_BITS'(y_term) + OFFSET_BITS'(x_term);
                active_next    = (start_vw != '0) && (start_vh != '0);
            end
            else if (active_reg)
            begin
                if (col_inc >= row_bytes)
                begin
                    col_next      = '0;
                    row_next      = row_inc[COORD_BITS-1:0];
                    row_base_next = row_base_reg + OFFSET_BITS'(cfg.line_pitch);
                    if (row_inc[COORD_BITS-1:0] >= bm_height_reg)
                        active_next = 1'b0;
                end
                else
                begin
                    col_next = col_inc[COL_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bm_width_reg  <= '0;
            bm_height_reg <= '0;
            vis_w_reg     <= '0;
            vis_h_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            bm_width_reg  <= bm_width_next;
            bm_height_reg <= bm_height_next;
            vis_w_reg     <= vis_w_next;
            vis_h_reg     <= vis_h_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_base_reg  <= row_base_next;
        end
    end

endmodule

// ----- sv/mbce_queue.sv -----
module mbce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mbce_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output mbce_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import mbce_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QPTR_BITS] != rd_ptr_reg[QPTR_BITS])
                   && (wr_ptr_reg[QPTR_BITS-1:0] == rd_ptr_reg[QPTR_BITS-1:0]);
    assign pop_cmd = entry_reg[rd_ptr_reg[QPTR_BITS-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (QPTR_BITS+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (QPTR_BITS+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg[QPTR_BITS-1:0]] <= push_cmd;
    end

endmodule

// ----- sv/mbce_back.sv -----
module mbce_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mbce_pkg::cfg_t                   cfg,
    input  mbce_pkg::cmd_t                   q_cmd,
    input  logic                             q_empty,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mbce_pkg::OFFSET_BITS-1:0] out_offset,
    output logic [mbce_pkg::CHAN_BITS-1:0]   out_red,
    output logic [mbce_pkg::CHAN_BITS-1:0]   out_green,
    output logic [mbce_pkg::CHAN_BITS-1:0]   out_blue,
    output logic                             out_last_byte,
    output logic                             out_last_bitmap
);
    import mbce_pkg::*;

    logic                   busy_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [CHAN_BITS-1:0]   data_reg;
    logic [COUNT_BITS-1:0]  left_reg;
    logic                   last_bm_reg;

    logic                   out_valid_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [COLOR_BITS-1:0]  out_color_reg;
    logic                   out_lbyte_reg;
    logic                   out_lbm_reg;

    logic                   emit;
    logic                   final_pix;

    assign emit      = busy_reg && (!out_valid_reg || out_ready);
    assign final_pix = (left_reg == COUNT_BITS'(1));
    assign q_pop     = !q_empty && (!busy_reg || (emit && final_pix));

    assign out_valid       = out_valid_reg;
    assign out_offset      = out_offset_reg;
    assign out_red         = out_color_reg[3*CHAN_BITS-1:2*CHAN_BITS];
    assign out_green       = out_color_reg[2*CHAN_BITS-1:CHAN_BITS];
    assign out_blue        = out_color_reg[CHAN_BITS-1:0];
    assign out_last_byte   = out_lbyte_reg;
    assign out_last_bitmap = out_lbm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                busy_reg <= 1'b1;
            else if (emit && final_pix)
                busy_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: current byte being expanded and the output slot
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            offset_reg  <= q_cmd.offset;
            data_reg    <= q_cmd.data;
            left_reg    <= q_cmd.count;
            last_bm_reg <= q_cmd.last_bitmap;
        end
        else if (emit)
        begin
            offset_reg <= offset_reg + OFFSET_BITS'(cfg.bytes_per_pixel);
            data_reg   <= {data_reg[CHAN_BITS-2:0], 1'b0};
            left_reg   <= left_reg - COUNT_BITS'(1);
        end

        if (emit)
        begin
            out_offset_reg <= offset_reg;
            out_color_reg  <= data_reg[CHAN_BITS-1] ? cfg.fore_color : cfg.back_color;
            out_lbyte_reg  <= final_pix;
            out_lbm_reg    <= final_pix && last_bm_reg;
        end
    end

endmodule

// ----- sv/mono_bitmap_color_expand.sv -----
// A byte request passes the queue, the expansion registers and the output register
// before its first pixel shows. Throughput: one pixel per cycle while m_axis_tready
// is high; the single-pixel expansion stage gives a byte's visible pixels (up to 8).
// Start requests and bytes with no visible pixel are not queued. A 4-entry queue
// decouples input. Reset (rst_n low, asynchronous): no rectangle, queue and output
// empty, registers back to 640x480, pitch 2560, 4 bytes per pixel, white on black.
`include "mono_bitmap_color_expand_assert.svh"

module mono_bitmap_color_expand (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // rect_x, rect_y, rect_width, rect_height, bitmap_byte
    input  logic [mbce_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // mode
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // pixel_offset, red, green, blue, zero fill
    output logic [mbce_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // last_of_byte
    output logic                                  m_axis_tuser,
    // last_of_bitmap
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mbce_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mbce_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mbce_pkg::*;

    cfg_t                   cfg_reg;
    logic                   q_push, q_pop, q_full, q_empty;
    cmd_t                   push_cmd, pop_cmd;
    logic [OFFSET_BITS-1:0] pix_offset;
    logic [CHAN_BITS-1:0]   pix_red, pix_green, pix_blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= COORD_BITS'(640);
            cfg_reg.screen_height   <= COORD_BITS'(480);
            cfg_reg.line_pitch      <= PITCH_BITS'(2560);
            cfg_reg.bytes_per_pixel <= BPP_BITS'(4);
            cfg_reg.fore_color      <= '1;
            cfg_reg.back_color      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:    cfg_reg.screen_width    <= cfg_data[COORD_BITS-1:0];
                REG_SCREEN_HEIGHT:   cfg_reg.screen_height   <= cfg_data[COORD_BITS-1:0];
                REG_LINE_PITCH:      cfg_reg.line_pitch      <= cfg_data[PITCH_BITS-1:0];
                REG_BYTES_PER_PIXEL: cfg_reg.bytes_per_pixel <= cfg_data[BPP_BITS-1:0];
                REG_FORE_COLOR:      cfg_reg.fore_color      <= cfg_data[COLOR_BITS-1:0];
                REG_BACK_COLOR:      cfg_reg.back_color      <= cfg_data[COLOR_BITS-1:0];
                default:             ;
            endcase
        end
    end

    mbce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_x     (s_axis_tdata[COORD_BITS-1:0]),
        .in_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_w     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .in_h     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .in_byte  (s_axis_tdata[4*COORD_BITS+CHAN_BITS-1:4*COORD_BITS]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    mbce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    mbce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_cmd           (pop_cmd),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_offset      (pix_offset),
        .out_red         (pix_red),
        .out_green       (pix_green),
        .out_blue        (pix_blue),
        .out_last_byte   (m_axis_tuser),
        .out_last_bitmap (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({pix_blue, pix_green, pix_red, pix_offset});

    `MBCE_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
    `MBCE_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_empty)
    `MBCE_ASSERT_NEXT(a_queue_fills, q_push && q_empty && !q_pop, !q_empty)
    `MBCE_ASSERT_IMP(a_bitmap_end_ends_byte, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

endmodule
